// ===== rtl/core/line_fixed_string_matcher_core_macros.svh =====
// ----------------------------------------------------------------------------
// line fixed string matcher assertion macros
// shared assertion forms for the matcher core, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef LINE_FIXED_STRING_MATCHER_CORE_MACROS_SVH
`define LINE_FIXED_STRING_MATCHER_CORE_MACROS_SVH

// condition that must hold at every edge out of reset
`define LFSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// trigger at one edge implies the expectation at the next edge
`define LFSM_ASSERT_NEXT(label, trig, expect_now, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (trig) |=> (expect_now)) else $error(msg);

`endif

// ===== rtl/core/lfsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_pkg
// shared constants, types and helpers of the line fixed string matcher
// ----------------------------------------------------------------------------
package lfsm_pkg;

  // pattern and line limits
  localparam int PATTERN_MAX   = 32;
  localparam int PATTERN_BYTES = 32;
  localparam int PATTERN_WORDS = 4;
  localparam int MAX_LINE      = 4096;
  localparam int FILL_W        = $clog2(MAX_LINE);
  localparam int EFF_W         = $clog2(PATTERN_MAX + 1);

  // configuration register layout
  localparam int CFG_WORD_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int MODE_W      = 4;
  localparam int LEN_W       = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE           = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD_3 = 3'd5;

  // mode bits
  localparam int MODE_FOLD       = 0;
  localparam int MODE_INVERT     = 1;
  localparam int MODE_COUNT_ONLY = 2;
  localparam int MODE_STOP_FIRST = 3;

  // stream codes
  localparam logic ACTION_END   = 1'b1;
  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // characters
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  // result queue and output packing
  localparam int COUNT_W    = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_BITS   = 2 * COUNT_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // per-cell controls
  typedef struct packed {
    logic step;
    logic clear;
    logic enable;
    logic tail;
  } cell_ctl_t;

  // one result item
  typedef struct packed {
    logic               result_kind;
    logic [COUNT_W-1:0] line_number;
    logic [COUNT_W-1:0] match_count;
    logic               found_flag;
    logic               last_result;
  } result_t;

  // ascii upper case to lower case when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  // saturating increment of a counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == '1) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/lfsm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_cell
// one position of the shift-and chain: holds one partial match bit
// ----------------------------------------------------------------------------
module lfsm_cell (
  input  logic               clk,
  input  logic               rst,
  input  lfsm_pkg::cell_ctl_t ctl,
  input  logic [7:0]         data_in,
  input  logic [7:0]         pattern_in,
  input  logic               prev_bit,
  output logic               match_bit,
  output logic               hit
);

  logic bit_next;

  // prefix of length j+1 still matches when the shorter one did and this byte agrees
  assign bit_next = prev_bit & ctl.enable & (data_in == pattern_in);
  assign hit      = ctl.tail & bit_next;

  // partial match bit, cleared at each line end and at end of stream
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      match_bit <= 1'b0;
    end else if (ctl.step) begin
      match_bit <= bit_next;
    end
  end

endmodule

// ===== rtl/core/lfsm_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_result_fifo
// small result queue, takes up to two results a cycle and hands out one
// ----------------------------------------------------------------------------
module lfsm_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        wr_count,
  input  lfsm_pkg::result_t wr_first,
  input  lfsm_pkg::result_t wr_second,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output lfsm_pkg::result_t out_data
);

  lfsm_pkg::result_t mem [lfsm_pkg::FIFO_DEPTH];

  logic [lfsm_pkg::PTR_W-1:0] wptr;
  logic [lfsm_pkg::PTR_W-1:0] wptr_plus;
  logic [lfsm_pkg::PTR_W-1:0] rptr;
  logic [lfsm_pkg::CNT_W-1:0] count;
  logic                       pop;

  assign pop       = out_valid & out_ready;
  assign wptr_plus = wptr + 1'b1;

  // room for a worst case of two results
  assign room      = count <= lfsm_pkg::CNT_W'(lfsm_pkg::FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wptr] <= wr_first;
    end
    if (wr_count == 2'd2) begin
      mem[wptr_plus] <= wr_second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + lfsm_pkg::PTR_W'(wr_count);
      rptr  <= rptr + lfsm_pkg::PTR_W'(pop);
      count <= count + lfsm_pkg::CNT_W'(wr_count) - lfsm_pkg::CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/core/line_fixed_string_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_fixed_string_matcher_core
// line-oriented fixed string search over a byte stream
// ----------------------------------------------------------------------------
// Takes one stream byte (or an end-of-stream mark) per transfer and accepts
// a new transfer every cycle while the result queue has room. Each byte
// updates a row of 32 shift-and cells; a line ends at newline or after 4095
// bytes, and each selected line is reported by number unless count-only or
// stop-at-first is set. End of stream yields a summary with line count, match
// count and found flag. Results go through a four-entry queue; input ready
// drops while fewer than two entries are free, so a byte stream sustains one
// byte per cycle while the receiver keeps up, and an end-of-stream mark may
// yield two results. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "line_fixed_string_matcher_core_macros.svh"

module line_fixed_string_matcher_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [lfsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lfsm_pkg::CFG_WORD_W-1:0]     cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tuser,  // [0] action
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] line_number, [63:32] match_count, [64] found_flag, rest zero
  output logic [lfsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] result_kind
  output logic                                m_axis_tlast   // last_result
);

  localparam int NCELL = lfsm_pkg::PATTERN_MAX;

  // configuration registers
  logic [lfsm_pkg::MODE_W-1:0]     mode;
  logic [lfsm_pkg::LEN_W-1:0]      pattern_length;
  logic [lfsm_pkg::CFG_WORD_W-1:0] pattern_word [lfsm_pkg::PATTERN_WORDS];

  // stream state
  logic                            line_hit;
  logic [lfsm_pkg::FILL_W-1:0]     line_fill;
  logic [lfsm_pkg::COUNT_W-1:0]    line_counter;
  logic [lfsm_pkg::COUNT_W-1:0]    selected_counter;
  logic                            any_selected;
  logic                            stopped;

  // chain signals
  logic [NCELL-1:0]                match_vec;
  logic [NCELL-1:0]                cell_hit;
  logic [7:0]                      data_folded;
  logic [lfsm_pkg::EFF_W-1:0]      eff_len;

  // item decode
  logic accept, is_end, is_nl, data_live, step, cut, line_end, hit_now, sel;
  logic report, summary, chain_clear;
  logic [lfsm_pkg::COUNT_W-1:0] lc_after, sc_after;
  logic any_after;

  // results
  lfsm_pkg::result_t res0, res1, res_out;
  logic [1:0]        res_n;
  logic              room;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= '0;
      pattern_length <= '0;
      for (int w = 0; w < lfsm_pkg::PATTERN_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        lfsm_pkg::CFG_MODE:           mode            <= cfg_data[lfsm_pkg::MODE_W-1:0];
        lfsm_pkg::CFG_PATTERN_LENGTH: pattern_length  <= cfg_data[lfsm_pkg::LEN_W-1:0];
        lfsm_pkg::CFG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        lfsm_pkg::CFG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        lfsm_pkg::CFG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        lfsm_pkg::CFG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective pattern length, limited to the chain length
  assign eff_len = (pattern_length > lfsm_pkg::LEN_W'(lfsm_pkg::PATTERN_MAX))
                 ? lfsm_pkg::EFF_W'(lfsm_pkg::PATTERN_MAX)
                 : lfsm_pkg::EFF_W'(pattern_length);

  // item decode
  assign accept      = s_axis_tvalid & s_axis_tready;
  assign is_end      = s_axis_tuser == lfsm_pkg::ACTION_END;
  assign is_nl       = s_axis_tdata == lfsm_pkg::CHAR_NEWLINE;
  assign data_live   = accept & ~is_end & ~stopped;
  assign step        = data_live & ~is_nl & (eff_len != '0);
  assign cut         = data_live & ~is_nl
                     & (line_fill == lfsm_pkg::FILL_W'(lfsm_pkg::MAX_LINE - 2));
  assign line_end    = (data_live & is_nl) | cut
                     | (accept & is_end & ~stopped & (line_fill != '0));
  assign summary     = accept & is_end;
  assign chain_clear = line_end | summary;
  assign data_folded = lfsm_pkg::fold_byte(s_axis_tdata, mode[lfsm_pkg::MODE_FOLD]);

  // shift-and chain
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    lfsm_pkg::cell_ctl_t ctl;
    logic [7:0]          pat;
    logic                prev;

    if (j < lfsm_pkg::PATTERN_BYTES) begin : g_pat
      assign pat = lfsm_pkg::fold_byte(pattern_word[j / 8][(j % 8) * 8 +: 8],
                                       mode[lfsm_pkg::MODE_FOLD]);
    end else begin : g_zero
      assign pat = 8'h00;
    end

    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_vec[j-1];
    end

    assign ctl.step   = step;
    assign ctl.clear  = chain_clear;
    assign ctl.enable = lfsm_pkg::EFF_W'(j) < eff_len;
    assign ctl.tail   = lfsm_pkg::EFF_W'(j + 1) == eff_len;

    lfsm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .data_in    (data_folded),
      .pattern_in (pat),
      .prev_bit   (prev),
      .match_bit  (match_vec[j]),
      .hit        (cell_hit[j])
    );
  end

  // line selection and counters after this item
  assign hit_now   = step & (|cell_hit);
  assign sel       = ((eff_len == '0) | line_hit | hit_now) ^ mode[lfsm_pkg::MODE_INVERT];
  assign lc_after  = line_end ? lfsm_pkg::sat_inc(line_counter) : line_counter;
  assign sc_after  = (line_end & sel) ? lfsm_pkg::sat_inc(selected_counter)
                                      : selected_counter;
  assign any_after = any_selected | (line_end & sel);
  assign report    = line_end & sel & ~mode[lfsm_pkg::MODE_STOP_FIRST]
                   & ~mode[lfsm_pkg::MODE_COUNT_ONLY];

  // result assembly: optional line report, then summary on end of stream
  always_comb begin
    res0.result_kind = lfsm_pkg::KIND_LINE;
    res0.line_number = lc_after;
    res0.match_count = sc_after;
    res0.found_flag  = any_after;
    res0.last_result = 1'b1;
    res1             = res0;
    res1.result_kind = lfsm_pkg::KIND_SUMMARY;
    res_n            = 2'd0;
    if (report && summary) begin
      res0.last_result = 1'b0;
      res_n            = 2'd2;
    end else if (report) begin
      res_n = 2'd1;
    end else if (summary) begin
      res0  = res1;
      res_n = 2'd1;
    end
  end

  // stream state update
  always_ff @(posedge clk) begin
    if (rst) begin
      line_hit         <= 1'b0;
      line_fill        <= '0;
      line_counter     <= '0;
      selected_counter <= '0;
      any_selected     <= 1'b0;
      stopped          <= 1'b0;
    end else if (summary) begin
      line_hit         <= 1'b0;
      line_fill        <= '0;
      line_counter     <= '0;
      selected_counter <= '0;
      any_selected     <= 1'b0;
      stopped          <= 1'b0;
    end else begin
      if (line_end) begin
        line_hit  <= 1'b0;
        line_fill <= '0;
      end else if (data_live && !is_nl) begin
        line_hit  <= line_hit | hit_now;
        line_fill <= line_fill + 1'b1;
      end
      line_counter     <= lc_after;
      selected_counter <= sc_after;
      any_selected     <= any_after;
      if (line_end && sel && mode[lfsm_pkg::MODE_STOP_FIRST]) begin
        stopped <= 1'b1;
      end
    end
  end

  // result queue
  lfsm_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_count  (res_n),
    .wr_first  (res0),
    .wr_second (res1),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res_out)
  );

  assign s_axis_tready = room;
  assign m_axis_tdata  = {{(lfsm_pkg::OUT_DATA_W - lfsm_pkg::OUT_BITS){1'b0}},
                          res_out.found_flag, res_out.match_count, res_out.line_number};
  assign m_axis_tuser  = res_out.result_kind;
  assign m_axis_tlast  = res_out.last_result;

  // checks
  `LFSM_ASSERT_NEXT(a_end_gives_output, summary, m_axis_tvalid, "end of stream left no result")
  `LFSM_ASSERT(a_stopped_no_report, !(stopped && report), "line report while stopped")
  `LFSM_ASSERT_NEXT(a_line_end_clears, line_end, (match_vec == '0) && !line_hit, "line state kept")
  `LFSM_ASSERT_NEXT(a_select_sets_found, line_end && sel && !summary, any_selected, "found flag lost")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the line fixed string matcher core
// ----------------------------------------------------------------------------
// Drives byte streams and end-of-stream marks into the core and keeps its own
// shift-and model of line splitting, matching and selection. Every accepted
// input updates the model, which queues the line reports and summaries it
// expects. Each result transfer is checked field by field against the oldest
// queued entry. Directed tests cover every mode, the pattern length limits,
// long lines and a long output stall; random tests then run many
// configurations with random sender and receiver gaps, and one run without gaps.
// ----------------------------------------------------------------------------
module testbench;
  import lfsm_pkg::*;

  localparam logic ACTION_DATA     = 1'b0;
  localparam int   DRAIN_CYCLES    = 16;
  localparam int   HOLD_OFF_CYCLES = 600;
  localparam int   WATCHDOG_LIMIT  = 4000;
  localparam int   LONG_LINE_BYTES = 120;
  localparam int   RANDOM_BUDGET   = 200;

  // one expected or observed result
  typedef struct packed {
    logic               kind;
    logic [COUNT_W-1:0] number;
    logic [COUNT_W-1:0] count;
    logic               found;
    logic               last;
  } match_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_WORD_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;   // [7:0] data_byte
  logic                   s_axis_tuser = 1'b0; // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;        // [31:0] line, [63:32] count, [64] found
  logic                   m_axis_tuser;        // [0] result_kind
  logic                   m_axis_tlast;        // last_result

  line_fixed_string_matcher_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // model copy of the registers
  logic [MODE_W-1:0]     cfg_mode = '0;
  logic [LEN_W-1:0]      cfg_len = '0;
  logic [CFG_WORD_W-1:0] cfg_word [PATTERN_WORDS];

  // model copy of the stream state
  logic [31:0]        match_vec = '0;
  logic               line_hit = 1'b0;
  int unsigned        line_fill = 0;
  logic [COUNT_W-1:0] line_count = '0;
  logic [COUNT_W-1:0] sel_count = '0;
  logic               any_sel = 1'b0;
  logic               halted = 1'b0;

  match_result_t pending_reports [$];
  match_result_t seen, want;
  logic [7:0]    pat_bytes [PATTERN_BYTES];

  int  snd_idle_pct = 27;
  int  rcv_idle_pct = 69;
  bit  hold_off_active = 1'b0;
  event hold_off_go;
  bit  moved;
  int  quiet_cycles = 0;
  int  mismatches = 0;
  int  items_offered = 0;
  int  results_checked = 0;
  int  streams_closed = 0;
  int  configs_loaded = 0;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    foreach (cfg_word[w]) cfg_word[w] = '0;
    foreach (pat_bytes[j]) pat_bytes[j] = '0;
  end

  // ---------------------------------------------------------------------------
  // matcher model
  // ---------------------------------------------------------------------------
  function automatic int unsigned active_length();
    int unsigned n;
    n = cfg_len;
    return (n > PATTERN_MAX) ? PATTERN_MAX : n;
  endfunction

  function automatic logic [7:0] lower_if_folding(input logic [7:0] c);
    if (cfg_mode[MODE_FOLD] && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c + CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void queue_report(input logic kind, input logic [COUNT_W-1:0] num);
    match_result_t r;
    r.kind   = kind;
    r.number = num;
    r.count  = sel_count;
    r.found  = any_sel;
    r.last   = 1'b0;
    pending_reports.push_back(r);
  endfunction

  function automatic void clear_line();
    match_vec = '0;
    line_hit  = 1'b0;
    line_fill = 0;
  endfunction

  // shift-and step over one non-newline byte
  function automatic void scan_byte(input logic [7:0] c);
    int unsigned n;
    logic [31:0] hits;
    logic [7:0]  fc;
    n = active_length();
    if (n == 0) return;
    fc   = lower_if_folding(c);
    hits = '0;
    for (int j = 0; j < n; j++) begin
      if (lower_if_folding(cfg_word[j / 8][(j % 8) * 8 +: 8]) == fc) hits[j] = 1'b1;
    end
    match_vec = ((match_vec << 1) | 32'd1) & hits;
    if (match_vec[n - 1]) line_hit = 1'b1;
  endfunction

  // end of a line: selection, counters and the optional report
  function automatic void close_line();
    logic sel;
    sel = (active_length() == 0) || line_hit;
    if (cfg_mode[MODE_INVERT]) sel = !sel;
    line_count = bump(line_count);
    clear_line();
    if (!sel) return;
    sel_count = bump(sel_count);
    any_sel   = 1'b1;
    if (cfg_mode[MODE_STOP_FIRST]) begin
      halted = 1'b1;
      return;
    end
    if (cfg_mode[MODE_COUNT_ONLY]) return;
    queue_report(KIND_LINE, line_count);
  endfunction

  function automatic void scan_stream_item(input logic action, input logic [7:0] c);
    int prior_size;
    prior_size = pending_reports.size();
    if (action != ACTION_END) begin
      if (!halted) begin
        if (c == CHAR_NEWLINE) begin
          close_line();
        end else begin
          scan_byte(c);
          line_fill++;
          if (line_fill >= MAX_LINE - 1) close_line();
        end
      end
    end else begin
      if (!halted && line_fill > 0) close_line();
      queue_report(KIND_SUMMARY, line_count);
      streams_closed++;
      clear_line();
      line_count = '0;
      sel_count  = '0;
      any_sel    = 1'b0;
      halted     = 1'b0;
    end
    if (pending_reports.size() > prior_size)
      pending_reports[pending_reports.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // transfer monitor, result checker and watchdog
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what, input match_result_t e,
                                        input match_result_t a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: expected kind %0d line %0d count %0d found %0d last %0d,",
               what, $realtime, e.kind, e.number, e.count, e.found, e.last);
      $display("  got kind %0d line %0d count %0d found %0d last %0d",
               a.kind, a.number, a.count, a.found, a.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      // input side first so a result is never checked ahead of its cause
      if (s_axis_tvalid && s_axis_tready) begin
        scan_stream_item(s_axis_tuser, s_axis_tdata);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind   = m_axis_tuser;
        seen.number = m_axis_tdata[COUNT_W-1:0];
        seen.count  = m_axis_tdata[2*COUNT_W-1:COUNT_W];
        seen.found  = m_axis_tdata[2*COUNT_W];
        seen.last   = m_axis_tlast;
        results_checked++;
        moved = 1'b1;
        if (pending_reports.size() == 0) begin
          flag_mismatch("nothing expected", seen, seen);
        end else begin
          want = pending_reports.pop_front();
          if (want.kind != seen.kind || want.number != seen.number || want.count != seen.count ||
              want.found != seen.found || want.last != seen.last)
            flag_mismatch("field differs", want, seen);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_reports.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, or held low during a hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off_active) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(hold_off_go);
      hold_off_active = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      hold_off_active = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sender and configuration helpers
  // ---------------------------------------------------------------------------
  // one input transfer; valid stays high after it for a following item
  task automatic send_item(input logic action, input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    items_offered++;
  endtask

  task automatic send_data(input logic [7:0] c);
    send_item(ACTION_DATA, c);
  endtask

  task automatic send_end();
    send_item(ACTION_END, 8'h00);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_data(s[i]);
  endtask

  task automatic wait_for_quiet();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_pattern_text(input string s);
    foreach (pat_bytes[j]) pat_bytes[j] = (j < s.len()) ? s[j] : 8'h00;
  endtask

  // all six registers, written on back-to-back cycles once the core is idle
  task automatic program_matcher(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] n);
    logic [CFG_WORD_W-1:0] w;
    wait_for_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= CFG_WORD_W'(m);
    cfg_mode   = m;
    @(negedge clk);
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_data  <= CFG_WORD_W'(n);
    cfg_len    = n;
    for (int k = 0; k < PATTERN_WORDS; k++) begin
      for (int b = 0; b < 8; b++) w[b * 8 +: 8] = pat_bytes[k * 8 + b];
      @(negedge clk);
      cfg_index  <= CFG_PATTERN_WORD_0 + CFG_INDEX_W'(k);
      cfg_data   <= w;
      cfg_word[k] = w;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    configs_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(9))
      0:       return "a";
      1:       return "b";
      2:       return "A";
      3:       return "B";
      4:       return "c";
      5:       return 8'h00;
      6:       return 8'hFF;
      7:       return "C";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    b = pick_symbol();
    return (b == CHAR_NEWLINE) ? 8'h78 : b;
  endfunction

  // flip letter case now and then when folding is on
  function automatic logic [7:0] case_jitter(input logic [7:0] b);
    logic letter;
    letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    if (cfg_mode[MODE_FOLD] && letter && $urandom_range(1)) return b ^ 8'h20;
    return b;
  endfunction

  task automatic random_config();
    logic [MODE_W-1:0] m;
    logic [LEN_W-1:0]  n;
    // stop mode only now and then, since it makes the core ignore bytes
    m = MODE_W'($urandom_range(7));
    if ($urandom_range(4) == 0) m[MODE_STOP_FIRST] = 1'b1;
    case ($urandom_range(9))
      0:       n = '0;
      1:       n = LEN_W'(1);
      7:       n = LEN_W'($urandom_range(7, 32));
      8:       n = LEN_W'(PATTERN_MAX);
      9:       n = LEN_W'($urandom_range(33, 63));
      default: n = LEN_W'($urandom_range(2, 6));
    endcase
    foreach (pat_bytes[j]) pat_bytes[j] = pick_symbol();
    program_matcher(m, n);
  endtask

  // a line holding the pattern, a broken prefix of it, filler or raw noise
  task automatic send_random_line();
    int roll, n, part;
    roll = $urandom_range(9);
    n    = active_length();
    if (roll == 0) begin
      repeat ($urandom_range(1, 12)) send_data(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(0, 6)) send_data(filler_byte());
    if (roll <= 5) begin
      for (int j = 0; j < n; j++) send_data(case_jitter(pat_bytes[j]));
    end else if (roll == 6 && n > 1) begin
      part = $urandom_range(1, n - 1);
      for (int j = 0; j < part; j++) send_data(case_jitter(pat_bytes[j]));
    end
    repeat ($urandom_range(0, 6)) send_data(filler_byte());
    if ($urandom_range(9) != 0) send_data(CHAR_NEWLINE);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // folded match, byte extremes, empty line, open line at end, empty stream
  task automatic test_basics();
    set_pattern_text("AbC");
    program_matcher(4'b0001, 6'd3);
    send_text("xaBc\n");
    send_data(8'h00);
    send_data(8'hFF);
    send_text("\n\nABC");
    send_end();
    send_end();
    send_text("abc\n");
    send_end();
  endtask

  // every mode combination over the same text
  task automatic test_mode_sweep();
    for (int m = 0; m < 16; m++) begin
      set_pattern_text("aBc");
      program_matcher(MODE_W'(m), 6'd3);
      send_text("xyz\nzABCz\nxaBcx\nq");
      send_data(8'h00);
      send_text("aBc");
      send_end();
      send_text("abc\n");
      send_end();
    end
  endtask

  // empty, single byte, full and over-long patterns
  task automatic test_pattern_extremes();
    set_pattern_text("");
    program_matcher(4'b0000, 6'd0);
    send_text("\na\n\n");
    send_end();
    program_matcher(4'b0010, 6'd0);
    send_text("b\n");
    send_end();
    pat_bytes[0] = 8'hFF;
    program_matcher(4'b0000, 6'd1);
    send_data(8'hFF);
    send_data(CHAR_NEWLINE);
    send_data(8'hFE);
    send_data(CHAR_NEWLINE);
    send_end();
    // newline in the pattern never matches
    pat_bytes[0] = CHAR_NEWLINE;
    program_matcher(4'b0000, 6'd1);
    send_text("x\n");
    send_end();
    foreach (pat_bytes[j]) begin
      case (j % 4)
        0:       pat_bytes[j] = 8'h00;
        1:       pat_bytes[j] = 8'hFF;
        2:       pat_bytes[j] = 8'(8'h41 + j);
        default: pat_bytes[j] = 8'(8'h80 | j);
      endcase
    end
    program_matcher(4'b0000, 6'd32);
    send_data("q");
    foreach (pat_bytes[j]) send_data(pat_bytes[j]);
    send_data(CHAR_NEWLINE);
    for (int j = 1; j < PATTERN_BYTES; j++) send_data(pat_bytes[j]);
    send_data(CHAR_NEWLINE);
    send_end();
    // length above the limit acts as the full pattern
    program_matcher(4'b0000, 6'd63);
    foreach (pat_bytes[j]) send_data(pat_bytes[j]);
    send_end();
  endtask

  // long lines with the pattern at the far end, or only its first byte
  task automatic test_long_line();
    int saved;
    saved        = snd_idle_pct;
    snd_idle_pct = 0;
    set_pattern_text("ab");
    program_matcher(4'b0000, 6'd2);
    repeat (LONG_LINE_BYTES) send_data("x");
    send_text("ab\n");
    repeat (LONG_LINE_BYTES) send_data("z");
    send_text("a");
    send_end();
    snd_idle_pct = saved;
  endtask

  // receiver holds off long enough for the core to stall its input
  task automatic test_output_stall();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_pattern_text("ab");
    program_matcher(4'b0000, 6'd2);
    @(posedge clk);
    -> hold_off_go;
    repeat (40) send_text("ab\n");
    send_end();
  endtask

  task automatic test_random(input int snd, input int rcv, input int budget);
    int start;
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    start        = items_offered;
    while (items_offered - start < budget) begin
      random_config();
      repeat ($urandom_range(3, 8)) send_random_line();
      // some configurations change while a stream is still open
      if ($urandom_range(9) < 7) send_end();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_basics();
    test_mode_sweep();
    test_pattern_extremes();
    test_long_line();
    test_output_stall();
    test_random(27, 69, RANDOM_BUDGET);
    test_random(69, 27, RANDOM_BUDGET);
    test_random(0, 0, RANDOM_BUDGET);
    wait_for_quiet();
    mismatches += pending_reports.size();
    $display("run covered %0d input transfers, %0d results checked, %0d streams",
             items_offered, results_checked, streams_closed);
    $display("%0d register sets loaded, all 16 modes, long lines and output stall included",
             configs_loaded);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lfsm_pkg.sv
rtl/core/lfsm_cell.sv
rtl/core/lfsm_result_fifo.sv
rtl/core/line_fixed_string_matcher_core.sv
bench/testbench.sv
